// ===== design/frame_diff_dirty_rect_unit_macros.svh =====
// assertion macros shared by the frame difference unit
// no dependencies; taken in by the files that check their own logic
`ifndef FRAME_DIFF_DIRTY_RECT_UNIT_MACROS_SVH
`define FRAME_DIFF_DIRTY_RECT_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FDDR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define FDDR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/fddr_pkg.sv =====
// shared types, constants and the pixel repacking function of the frame difference unit
// no dependencies
package fddr_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_MAX_HEIGHT  = 1024;
    localparam int PIXELS_PER_WORD = 2;

    localparam int WORD_W        = 32;
    localparam int ADDR_OUT_W    = 19;
    localparam int RECT_LEFT_W   = 10;
    localparam int RECT_TOP_W    = 10;
    localparam int RECT_RIGHT_W  = 11;
    localparam int RECT_BOTTOM_W = 11;
    localparam int SIZE_W        = 11;
    localparam int SHIFT_W       = 5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam int M_TDATA_W = 96;
    localparam int M_TUSER_W = 2;

    localparam int OUT_FIFO_DEPTH = 3;

    localparam logic [WORD_W-1:0] CHECKER_A   = 32'h18e3_20e4;
    localparam logic [WORD_W-1:0] CHECKER_B   = 32'h20e4_18e3;
    localparam logic [WORD_W-1:0] CHECKER_FIX = 32'h18e3_18e3;
    localparam logic [WORD_W-1:0] FIVE_PAIR   = 32'h001f_001f;

    localparam logic [SIZE_W-1:0]  RST_SCREEN_WIDTH  = 11'd320;
    localparam logic [SIZE_W-1:0]  RST_SCREEN_HEIGHT = 11'd480;
    localparam logic [SHIFT_W-1:0] RST_RED_SHIFT     = 5'd11;
    localparam logic [SHIFT_W-1:0] RST_GREEN_SHIFT   = 5'd6;
    localparam logic [SHIFT_W-1:0] RST_BLUE_SHIFT    = 5'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_RED_SHIFT     = 3'd2,
        CFG_GREEN_SHIFT   = 3'd3,
        CFG_BLUE_SHIFT    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic                     write_remote;
        logic [ADDR_OUT_W-1:0]    word_address;
        logic [WORD_W-1:0]        remote_word;
        logic                     frame_done;
        logic                     rect_valid;
        logic [RECT_LEFT_W-1:0]   rect_left;
        logic [RECT_TOP_W-1:0]    rect_top;
        logic [RECT_RIGHT_W-1:0]  rect_right;
        logic [RECT_BOTTOM_W-1:0] rect_bottom;
    } result_t;

    // index width for n entries, at least one bit
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // checkerboard fixup, then 5:5:5 repack of both pixels
    function automatic logic [WORD_W-1:0] repack(input logic [WORD_W-1:0] word,
                                                 input logic [SHIFT_W-1:0] rs,
                                                 input logic [SHIFT_W-1:0] gs,
                                                 input logic [SHIFT_W-1:0] bs);
        logic [WORD_W-1:0] p;
        p = ((word == CHECKER_A) || (word == CHECKER_B)) ? CHECKER_FIX : word;
        return ((p >> rs) & FIVE_PAIR)
             | (((p >> gs) & FIVE_PAIR) << 5)
             | (((p >> bs) & FIVE_PAIR) << 10);
    endfunction

endpackage

// ===== design/fddr_addr_gen.sv =====
// raster position counters and compare store address for the incoming word
// depends on fddr_pkg
module fddr_addr_gen #(
    parameter int MAX_WIDTH  = fddr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fddr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic [fddr_pkg::SIZE_W-1:0]                   screen_width,
    input  logic [fddr_pkg::SIZE_W-1:0]                   screen_height,
    input  logic                                          advance,
    output logic [fddr_pkg::idx_w((MAX_WIDTH/2)*MAX_HEIGHT)-1:0] addr,
    output logic [fddr_pkg::idx_w(MAX_WIDTH)-1:0]         col,
    output logic [fddr_pkg::idx_w(MAX_HEIGHT)-1:0]        line,
    output logic                                          frame_end
);
    import fddr_pkg::*;

    localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_HEIGHT;
    localparam int ADDR_W = idx_w(DEPTH);
    localparam int COL_W  = idx_w(MAX_WIDTH);
    localparam int LINE_W = idx_w(MAX_HEIGHT);
    localparam int W_W    = $clog2(MAX_WIDTH + 1);
    localparam int H_W    = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W = LINE_W + W_W;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;

    logic [SIZE_W-1:0] sw_even;
    logic [W_W-1:0]    w_eff;
    logic [W_W-1:0]    half_w;
    logic [H_W-1:0]    h_eff;
    logic [PROD_W-1:0] prod;
    logic [W_W:0]      col_plus;
    logic [H_W:0]      line_plus;
    logic              line_end;
    logic              last_line;

    always_comb begin
        sw_even = {screen_width[SIZE_W-1:1], 1'b0};
        if (sw_even < SIZE_W'(2)) begin
            w_eff = W_W'(2);
        end else if (32'(sw_even) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(sw_even);
        end
        if (screen_height == '0) begin
            h_eff = H_W'(1);
        end else if (32'(screen_height) > MAX_HEIGHT) begin
            h_eff = H_W'(MAX_HEIGHT);
        end else begin
            h_eff = H_W'(screen_height);
        end
        half_w = w_eff >> 1;
    end

    always_comb begin
        prod      = PROD_W'(line_reg) * PROD_W'(half_w);
        addr      = ADDR_W'(prod) + ADDR_W'(col_reg >> 1);
        col_plus  = (W_W+1)'(col_reg) + (W_W+1)'(PIXELS_PER_WORD);
        line_plus = (H_W+1)'(line_reg) + (H_W+1)'(1);
        // a shrunk size ends the line or frame at the current word
        line_end  = col_plus >= (W_W+1)'(w_eff);
        last_line = line_plus >= (H_W+1)'(h_eff);
        frame_end = line_end && last_line;
        col       = col_reg;
        line      = line_reg;
    end

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        if (advance) begin
            if (line_end) begin
                col_next  = '0;
                line_next = last_line ? '0 : LINE_W'(line_plus);
            end else begin
                col_next = COL_W'(col_plus);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            line_reg <= '0;
        end else begin
            col_reg  <= col_next;
            line_reg <= line_next;
        end
    end

endmodule

// ===== design/fddr_store.sv =====
// compare store: previous frame copy, one write and one registered read port
// clears itself after reset; depends on fddr_pkg
module fddr_store #(
    parameter int MAX_WIDTH  = fddr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fddr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          rd_en,
    input  logic [fddr_pkg::idx_w((MAX_WIDTH/2)*MAX_HEIGHT)-1:0] rd_addr,
    output logic [fddr_pkg::WORD_W-1:0]                   rd_data,
    input  logic                                          wr_en,
    input  logic [fddr_pkg::idx_w((MAX_WIDTH/2)*MAX_HEIGHT)-1:0] wr_addr,
    input  logic [fddr_pkg::WORD_W-1:0]                   wr_data,
    output logic                                          clearing
);
    import fddr_pkg::*;

    localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_HEIGHT;
    localparam int ADDR_W = idx_w(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    always_comb begin
        mem_we    = clearing_reg || wr_en;
        mem_waddr = clearing_reg ? clr_addr_reg : wr_addr;
        mem_wdata = clearing_reg ? '0 : wr_data;
    end

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

// ===== design/fddr_out_fifo.sv =====
// three-entry result queue in front of the master stream port
// depends on fddr_pkg
module fddr_out_fifo (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          push,
    input  fddr_pkg::result_t                             push_data,
    output logic [$clog2(fddr_pkg::OUT_FIFO_DEPTH+1)-1:0] count,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output fddr_pkg::result_t                             out_data
);
    import fddr_pkg::*;

    localparam int PTR_W = idx_w(OUT_FIFO_DEPTH);
    localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

    result_t           entry_reg [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        pop         = (count_reg != '0) && out_ready;
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count     = count_reg;
    assign out_valid = count_reg != '0;
    assign out_data  = entry_reg[rd_ptr_reg];

endmodule

// ===== design/frame_diff_dirty_rect_unit.sv =====
// top level of the frame difference unit: config registers, compare stage, dirty box
// depends on fddr_pkg, fddr_addr_gen, fddr_store, fddr_out_fifo and the macros header
//
// Usage: a frame streams in on s_* as 32-bit words, two 16-bit pixels each, raster
// order. Every accepted word yields exactly one result transaction on m_*: the word
// address, a write flag with the repacked 5:5:5 word when the word differs from the
// previous frame, and on the last word of the frame (m_tlast) the dirty rectangle.
// Path: an accepted word is registered in the compare stage, and its result then goes
// into the result queue, which drives m_*.
// Throughput: one word per clock while s_tready is high; the store is read at
// acceptance and written in the next cycle, forwarding back-to-back same-address words.
// Stall: results wait in a three-entry queue; s_tready drops while queued plus
// in-flight results reach three, and rises again as m_tready drains the queue.
// Reset: aresetn (synchronous, active low) clears the counters, the box and the
// queue, and starts a clearing pass over the (MAX_WIDTH/2)*MAX_HEIGHT words of the
// store (524288 at the defaults) during which s_tready is low. Config writes
// on cfg_* are taken at any time, and are meant to happen while the block is idle.
`include "frame_diff_dirty_rect_unit_macros.svh"
module frame_diff_dirty_rect_unit #(
    parameter int MAX_WIDTH  = fddr_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fddr_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // slave stream: pixel_word
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [fddr_pkg::WORD_W-1:0]         s_tdata,
    // master stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // word_address[18:0], remote_word[50:19], rect_left[60:51], rect_top[70:61],
    // rect_right[81:71], rect_bottom[92:82], zeros[95:93]
    output logic [fddr_pkg::M_TDATA_W-1:0]      m_tdata,
    // write_remote[0], rect_valid[1]
    output logic [fddr_pkg::M_TUSER_W-1:0]      m_tuser,
    // frame_done
    output logic                                m_tlast,
    // config write port
    input  logic                                cfg_wr_en,
    input  logic [fddr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fddr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import fddr_pkg::*;

    localparam int DEPTH  = (MAX_WIDTH / 2) * MAX_HEIGHT;
    localparam int ADDR_W = idx_w(DEPTH);
    localparam int COL_W  = idx_w(MAX_WIDTH);
    localparam int LINE_W = idx_w(MAX_HEIGHT);
    localparam int CNT_W  = $clog2(OUT_FIFO_DEPTH + 1);

    // config registers
    logic [SIZE_W-1:0]  screen_width_reg, screen_width_next;
    logic [SIZE_W-1:0]  screen_height_reg, screen_height_next;
    logic [SHIFT_W-1:0] red_shift_reg, red_shift_next;
    logic [SHIFT_W-1:0] green_shift_reg, green_shift_next;
    logic [SHIFT_W-1:0] blue_shift_reg, blue_shift_next;

    always_comb begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        red_shift_next     = red_shift_reg;
        green_shift_next   = green_shift_reg;
        blue_shift_next    = blue_shift_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCREEN_WIDTH:  screen_width_next  = cfg_wdata;
                CFG_SCREEN_HEIGHT: screen_height_next = cfg_wdata;
                CFG_RED_SHIFT:     red_shift_next     = cfg_wdata[SHIFT_W-1:0];
                CFG_GREEN_SHIFT:   green_shift_next   = cfg_wdata[SHIFT_W-1:0];
                CFG_BLUE_SHIFT:    blue_shift_next    = cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg  <= RST_SCREEN_WIDTH;
            screen_height_reg <= RST_SCREEN_HEIGHT;
            red_shift_reg     <= RST_RED_SHIFT;
            green_shift_reg   <= RST_GREEN_SHIFT;
            blue_shift_reg    <= RST_BLUE_SHIFT;
        end else begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            red_shift_reg     <= red_shift_next;
            green_shift_reg   <= green_shift_next;
            blue_shift_reg    <= blue_shift_next;
        end
    end

    // acceptance stage
    logic              accept;
    logic              store_clearing;
    logic [CNT_W-1:0]  fifo_count;
    logic [CNT_W:0]    occ;
    logic [ADDR_W-1:0] addr0;
    logic [COL_W-1:0]  col0;
    logic [LINE_W-1:0] line0;
    logic              frame_end0;

    // compare stage
    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [LINE_W-1:0] s1_line_reg;
    logic              s1_frame_end_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] fwd_word_reg;

    logic [WORD_W-1:0] rd_data;
    logic [WORD_W-1:0] old_word;
    logic              changed;
    logic              upd;
    logic              store_wr_en;
    result_t           s1_result;
    result_t           fifo_out;

    // dirty box
    logic              box_any_reg, box_any_next;
    logic [COL_W-1:0]  box_min_col_reg, box_min_col_next;
    logic [COL_W-1:0]  box_max_col_reg, box_max_col_next;
    logic [LINE_W-1:0] box_min_line_reg, box_min_line_next;
    logic [LINE_W-1:0] box_max_line_reg, box_max_line_next;
    logic              any_cur;
    logic [COL_W-1:0]  min_col_cur, max_col_cur;
    logic [LINE_W-1:0] min_line_cur, max_line_cur;
    logic [COL_W:0]    right_full;
    logic [LINE_W:0]   bottom_full;

    always_comb begin
        occ      = (CNT_W+1)'(fifo_count) + (CNT_W+1)'(s1_valid_reg);
        s_tready = !store_clearing && (occ < (CNT_W+1)'(OUT_FIFO_DEPTH));
        accept   = s_tvalid && s_tready;
    end

    fddr_addr_gen #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_addr_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .advance       (accept),
        .addr          (addr0),
        .col           (col0),
        .line          (line0),
        .frame_end     (frame_end0)
    );

    fddr_store #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (addr0),
        .rd_data  (rd_data),
        .wr_en    (store_wr_en),
        .wr_addr  (s1_addr_reg),
        .wr_data  (s1_word_reg),
        .clearing (store_clearing)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_addr_reg      <= addr0;
            s1_word_reg      <= s_tdata;
            s1_col_reg       <= col0;
            s1_line_reg      <= line0;
            s1_frame_end_reg <= frame_end0;
            // the store read misses the word written at this same edge
            fwd_hit_reg      <= s1_valid_reg && (s1_addr_reg == addr0);
            fwd_word_reg     <= s1_word_reg;
        end
    end

    always_comb begin
        old_word    = fwd_hit_reg ? fwd_word_reg : rd_data;
        changed     = old_word != s1_word_reg;
        upd         = s1_valid_reg && changed;
        store_wr_en = upd;

        any_cur      = box_any_reg || upd;
        min_col_cur  = box_min_col_reg;
        max_col_cur  = box_max_col_reg;
        min_line_cur = box_min_line_reg;
        max_line_cur = box_max_line_reg;
        if (upd) begin
            if (!box_any_reg || (s1_col_reg < box_min_col_reg)) begin
                min_col_cur = s1_col_reg;
            end
            if (!box_any_reg || (s1_col_reg > box_max_col_reg)) begin
                max_col_cur = s1_col_reg;
            end
            if (!box_any_reg || (s1_line_reg < box_min_line_reg)) begin
                min_line_cur = s1_line_reg;
            end
            if (!box_any_reg || (s1_line_reg > box_max_line_reg)) begin
                max_line_cur = s1_line_reg;
            end
        end

        box_any_next      = any_cur;
        box_min_col_next  = min_col_cur;
        box_max_col_next  = max_col_cur;
        box_min_line_next = min_line_cur;
        box_max_line_next = max_line_cur;
        if (s1_valid_reg && s1_frame_end_reg) begin
            box_any_next = 1'b0;
        end

        right_full  = (COL_W+1)'(max_col_cur) + (COL_W+1)'(PIXELS_PER_WORD);
        bottom_full = (LINE_W+1)'(max_line_cur) + (LINE_W+1)'(1);

        s1_result.write_remote = changed;
        s1_result.word_address = ADDR_OUT_W'(s1_addr_reg);
        s1_result.remote_word  = changed ?
            repack(s1_word_reg, red_shift_reg, green_shift_reg, blue_shift_reg) : '0;
        s1_result.frame_done   = s1_frame_end_reg;
        s1_result.rect_valid   = s1_frame_end_reg && any_cur;
        s1_result.rect_left    = '0;
        s1_result.rect_top     = '0;
        s1_result.rect_right   = '0;
        s1_result.rect_bottom  = '0;
        if (s1_result.rect_valid) begin
            s1_result.rect_left   = RECT_LEFT_W'(min_col_cur);
            s1_result.rect_top    = RECT_TOP_W'(min_line_cur);
            s1_result.rect_right  = RECT_RIGHT_W'(right_full);
            s1_result.rect_bottom = RECT_BOTTOM_W'(bottom_full);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            box_any_reg <= 1'b0;
        end else begin
            box_any_reg <= box_any_next;
        end
    end

    always_ff @(posedge aclk) begin
        box_min_col_reg  <= box_min_col_next;
        box_max_col_reg  <= box_max_col_next;
        box_min_line_reg <= box_min_line_next;
        box_max_line_reg <= box_max_line_next;
    end

    fddr_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s1_valid_reg),
        .push_data (s1_result),
        .count     (fifo_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (fifo_out)
    );

    assign m_tdata = {3'b000, fifo_out.rect_bottom, fifo_out.rect_right, fifo_out.rect_top,
                      fifo_out.rect_left, fifo_out.remote_word, fifo_out.word_address};
    assign m_tuser = {fifo_out.rect_valid, fifo_out.write_remote};
    assign m_tlast = fifo_out.frame_done;

    `FDDR_ASSERT_IMPL(a_occupancy_bound, aclk, aresetn, 1'b1,
        occ <= (CNT_W+1)'(OUT_FIFO_DEPTH), "result queue overrun")
    `FDDR_ASSERT_NEXT(a_box_cleared_after_frame, aclk, aresetn,
        s1_valid_reg && s1_frame_end_reg, !box_any_reg, "box not cleared after frame end")
    `FDDR_ASSERT_IMPL(a_rect_only_at_frame_end, aclk, aresetn,
        s1_valid_reg && s1_result.rect_valid, s1_result.frame_done, "rect outside frame end")
    `FDDR_ASSERT_NEXT(a_forward_same_addr, aclk, aresetn,
        accept && s1_valid_reg && (s1_addr_reg == addr0), s1_valid_reg && fwd_hit_reg,
        "missed forwarding between words at one address")

endmodule
